FILE: hw/rtl/lut3d_pkg.sv
// ----------------------------------------------------------------------------
// lut3d_pkg
// Shared codes and fixed-point constants of the 3D LUT color mapper.
// ----------------------------------------------------------------------------
package lut3d_pkg;

	// input word commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// configuration register indexes
	localparam logic CFG_LUT_SIZE = 1'b0;
	localparam logic CFG_OPACITY  = 1'b1;

	// t / 255 as (t * DIV255_MUL) >> DIV255_SHIFT, exact for t below 2^14
	localparam int unsigned DIV255_MUL   = 16449;
	localparam int unsigned DIV255_SHIFT = 22;

	// final scale 255^2 and its reciprocal (underestimates by at most one)
	localparam int unsigned DENOM       = 65025;
	localparam int unsigned RECIP_MUL   = 66051;
	localparam int unsigned RECIP_SHIFT = 32;

	localparam int unsigned OPACITY_FULL = 256;

endpackage

FILE: hw/rtl/lut3d_trilinear_color_map.sv
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_map
// Trilinear 3D LUT color grading of 8-bit RGB pixels with opacity blend.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per cycle unless stalled:
//   cmd 0 loads a table entry at entry_address, cmd 1 maps the pixel
//   pixel_red/green/blue. Output channel (out_valid/out_ready) carries one
//   word per pixel; loads produce no output word.
//   Config channel (cfg_valid/cfg_ready, always ready) writes lut_size (index 0)
//   or opacity (index 1); write only while the pipeline is empty.
//   The 13-stage pipeline accepts one word per cycle unless the output stalls;
//   each corner read comes from its own copy of the table, so the eight
//   lattice corners are read in the same cycle.
//   Loads write the table copies in stage 7, the same stage that pixels read,
//   so words take effect in order.
//   Reset clears the pipeline valids and sets lut_size 33, opacity 256; table
//   contents are undefined until loaded.
//   When out_valid is high and out_ready low the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lut3d_trilinear_color_map #(
	parameter int MAX_LUT_SIZE = 33,
	parameter int ENTRY_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] entry_address,
	input  logic [15:0] entry_red,
	input  logic [15:0] entry_green,
	input  logic [15:0] entry_blue,
	input  logic [7:0]  pixel_red,
	input  logic [7:0]  pixel_green,
	input  logic [7:0]  pixel_blue,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int DEPTH = MAX_LUT_SIZE * MAX_LUT_SIZE * MAX_LUT_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_LUT_SIZE);
	localparam int NW    = $clog2(MAX_LUT_SIZE + 1);
	localparam int TW    = 8 + NW;
	localparam int EB    = ENTRY_BITS;
	localparam int CW1   = EB + 8;
	localparam int CW2   = EB + 16;
	localparam int CW3   = EB + 24;
	localparam int XW    = 24;
	localparam logic [CW3:0] HALF_D = (CW3 + 1)'(lut3d_pkg::DENOM) << (EB - 1);

	// ---------------- configuration ----------------
	logic [5:0]    lut_size_q;
	logic [8:0]    opacity_q;
	logic [NW-1:0] n_eff;
	logic [8:0]    op_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lut_size_q <= 6'd33;
			opacity_q  <= 9'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lut3d_pkg::CFG_LUT_SIZE: lut_size_q <= cfg_data[5:0];
				lut3d_pkg::CFG_OPACITY:  opacity_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (32'(lut_size_q) < 32'd2)
			n_eff = NW'(2);
		else if (32'(lut_size_q) > 32'(MAX_LUT_SIZE))
			n_eff = NW'(MAX_LUT_SIZE);
		else
			n_eff = NW'(lut_size_q);
		op_eff = (opacity_q > 9'd256) ? 9'd256 : opacity_q;
	end

	// ---------------- pipeline control ----------------
	logic en;
	logic pv_s1, pv_s2, pv_s3, pv_s4, pv_s5, pv_s6, pv_s7;
	logic pv_s8, pv_s9, pv_s10, pv_s11, pv_s12, pv_s13;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6;

	assign en        = !pv_s13 || out_ready;
	assign in_ready  = en;
	assign out_valid = pv_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{pv_s1, pv_s2, pv_s3, pv_s4, pv_s5, pv_s6, pv_s7} <= '0;
			{pv_s8, pv_s9, pv_s10, pv_s11, pv_s12, pv_s13}    <= '0;
			{ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6}        <= '0;
		end else if (en) begin
			pv_s1  <= in_valid && (cmd == lut3d_pkg::CMD_PIXEL);
			ld_s1  <= in_valid && (cmd == lut3d_pkg::CMD_LOAD) &&
			          (32'(entry_address) < 32'(DEPTH));
			pv_s2  <= pv_s1;  pv_s3  <= pv_s2;  pv_s4  <= pv_s3;
			pv_s5  <= pv_s4;  pv_s6  <= pv_s5;  pv_s7  <= pv_s6;
			pv_s8  <= pv_s7;  pv_s9  <= pv_s8;  pv_s10 <= pv_s9;
			pv_s11 <= pv_s10; pv_s12 <= pv_s11; pv_s13 <= pv_s12;
			ld_s2  <= ld_s1;  ld_s3  <= ld_s2;  ld_s4  <= ld_s3;
			ld_s5  <= ld_s4;  ld_s6  <= ld_s5;
		end
	end

	// ---------------- datapath registers ----------------
	logic [AW-1:0]   la_s1, la_s2, la_s3, la_s4, la_s5, la_s6;
	logic [3*EB-1:0] ld_s1_d, ld_s2_d, ld_s3_d, ld_s4_d, ld_s5_d, ld_s6_d;
	logic [7:0]      px_s1 [3], px_s2 [3], px_s3 [3], px_s4 [3], px_s5 [3], px_s6 [3];
	logic [7:0]      px_s7 [3], px_s8 [3], px_s9 [3], px_s10 [3], px_s11 [3], px_s12 [3];
	logic [TW-1:0]   t_s2 [3];
	logic [IW-1:0]   lo_s3 [3], hi_s3 [3], lo_s4 [3], hi_s4 [3];
	logic [7:0]      fr_s3 [3], fr_s4 [3], fr_s5 [3], fr_s6 [3], fr_s7 [3];
	logic [7:0]      fr_s8 [3], fr_s9 [3];
	logic [IW-1:0]   b_s5 [2];
	logic [AW-1:0]   rn_s4 [2];
	logic [AW-1:0]   rg_s5 [4];
	logic [AW-1:0]   addr_s6 [8];
	logic [3*EB-1:0] rd_s7 [8];
	logic [CW1-1:0]  cr_s8 [4][3];
	logic [CW2-1:0]  cg_s9 [2][3];
	logic [CW3-1:0]  s_s10 [3];
	logic [XW-1:0]   x_s11 [3];
	logic [8:0]      q_s11 [3];
	logic [7:0]      m_s12 [3];
	logic [7:0]      o_s13 [3];

	// combinational helpers
	logic [IW-1:0]   lo_c [3];
	logic [7:0]      fr_c [3];
	logic [31:0]     ext_r, ext_g, ext_b;
	logic [24:0]     rem_c [3];
	logic [8:0]      m9_c [3];

	assign ext_r = {16'b0, entry_red};
	assign ext_g = {16'b0, entry_green};
	assign ext_b = {16'b0, entry_blue};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lo_c[k] = IW'((32'(t_s2[k]) * 32'(lut3d_pkg::DIV255_MUL)) >>
			              lut3d_pkg::DIV255_SHIFT);
			fr_c[k] = 8'(t_s2[k] - TW'(32'(lo_c[k]) * 32'd255));
			rem_c[k] = 25'(x_s11[k]) - 25'(q_s11[k]) * 25'(lut3d_pkg::DENOM);
			m9_c[k]  = q_s11[k] + ((rem_c[k] >= 25'(lut3d_pkg::DENOM)) ? 9'd1 : 9'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: capture
			la_s1   <= AW'(entry_address);
			ld_s1_d <= {ext_b[EB-1:0], ext_g[EB-1:0], ext_r[EB-1:0]};
			px_s1[0] <= pixel_red;
			px_s1[1] <= pixel_green;
			px_s1[2] <= pixel_blue;

			la_s2 <= la_s1; la_s3 <= la_s2; la_s4 <= la_s3; la_s5 <= la_s4; la_s6 <= la_s5;
			ld_s2_d <= ld_s1_d; ld_s3_d <= ld_s2_d; ld_s4_d <= ld_s3_d;
			ld_s5_d <= ld_s4_d; ld_s6_d <= ld_s5_d;

			px_s2 <= px_s1; px_s3 <= px_s2; px_s4 <= px_s3; px_s5 <= px_s4;
			px_s6 <= px_s5; px_s7 <= px_s6; px_s8 <= px_s7; px_s9 <= px_s8;
			px_s10 <= px_s9; px_s11 <= px_s10; px_s12 <= px_s11;

			for (int k = 0; k < 3; k++) begin
				// s2: scale to lattice units
				t_s2[k] <= TW'(px_s1[k]) * TW'(n_eff - NW'(1));
				// s3: index and fraction
				lo_s3[k] <= lo_c[k];
				hi_s3[k] <= lo_c[k] + ((fr_c[k] != 8'd0) ? IW'(1) : IW'(0));
				fr_s3[k] <= fr_c[k];
			end
			lo_s4 <= lo_s3; hi_s4 <= hi_s3;
			fr_s4 <= fr_s3; fr_s5 <= fr_s4; fr_s6 <= fr_s5; fr_s7 <= fr_s6;
			fr_s8 <= fr_s7; fr_s9 <= fr_s8;

			// s4: red row offset
			rn_s4[0] <= AW'(lo_s3[0]) * AW'(n_eff);
			rn_s4[1] <= AW'(hi_s3[0]) * AW'(n_eff);

			// s5: red/green plane offset
			for (int i = 0; i < 2; i++) begin
				rg_s5[i*2]   <= (rn_s4[i] + AW'(lo_s4[1])) * AW'(n_eff);
				rg_s5[i*2+1] <= (rn_s4[i] + AW'(hi_s4[1])) * AW'(n_eff);
			end
			b_s5[0] <= lo_s4[2]; b_s5[1] <= hi_s4[2];

			// s6: corner addresses, bank = r*4 + g*2 + b
			for (int j = 0; j < 4; j++) begin
				addr_s6[j*2]   <= rg_s5[j] + AW'(b_s5[0]);
				addr_s6[j*2+1] <= rg_s5[j] + AW'(b_s5[1]);
			end

			// s8: along red
			for (int j = 0; j < 4; j++)
				for (int ch = 0; ch < 3; ch++)
					cr_s8[j][ch] <= CW1'(rd_s7[j][ch*EB +: EB]) * CW1'(8'd255 - fr_s7[0]) +
					                CW1'(rd_s7[j+4][ch*EB +: EB]) * CW1'(fr_s7[0]);

			// s9: along green
			for (int k = 0; k < 2; k++)
				for (int ch = 0; ch < 3; ch++)
					cg_s9[k][ch] <= CW2'(cr_s8[k][ch]) * CW2'(8'd255 - fr_s8[1]) +
					                CW2'(cr_s8[k+2][ch]) * CW2'(fr_s8[1]);

			for (int ch = 0; ch < 3; ch++) begin
				// s10: along blue
				s_s10[ch] <= CW3'(cg_s9[0][ch]) * CW3'(8'd255 - fr_s9[2]) +
				             CW3'(cg_s9[1][ch]) * CW3'(fr_s9[2]);
				// s11: round and estimate quotient by 255^2
				x_s11[ch] <= XW'(((CW3 + 1)'(s_s10[ch]) + HALF_D) >> EB);
				q_s11[ch] <= 9'((41'(XW'(((CW3 + 1)'(s_s10[ch]) + HALF_D) >> EB)) *
				                 41'(lut3d_pkg::RECIP_MUL)) >> lut3d_pkg::RECIP_SHIFT);
				// s12: correct quotient, saturate
				m_s12[ch] <= (m9_c[ch] > 9'd255) ? 8'd255 : m9_c[ch][7:0];
				// s13: opacity blend
				o_s13[ch] <= 8'((17'(px_s12[ch]) * 17'(9'(lut3d_pkg::OPACITY_FULL) - op_eff) +
				                 17'(m_s12[ch]) * 17'(op_eff)) >> 8);
			end
		end
	end

	// ---------------- table copies, one per corner ----------------
	for (genvar bk = 0; bk < 8; bk++) begin : g_bank
		logic [3*EB-1:0] mem [DEPTH];
		always_ff @(posedge clk) begin
			if (en) begin
				if (ld_s6)
					mem[la_s6] <= ld_s6_d;
				rd_s7[bk] <= mem[addr_s6[bk]];
			end
		end
	end

	assign out_red   = o_s13[0];
	assign out_green = o_s13[1];
	assign out_blue  = o_s13[2];

`ifndef NO_ASSERTIONS
	// upper lattice index is lower or next, never beyond the lattice
	a_lattice: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s3 |-> ((hi_s3[0] == lo_s3[0]) || (hi_s3[0] == lo_s3[0] + IW'(1))) &&
		          (32'(hi_s3[0]) < 32'(n_eff)) && (fr_s3[0] < 8'd255))
		else $error("lattice index out of range");

	// the far corner stays inside the table
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s6 |-> (32'(addr_s6[7]) < 32'(DEPTH)))
		else $error("corner address beyond table");

	// reciprocal estimate is low by at most one
	a_quot: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s11 |-> (rem_c[0] < 25'(2 * lut3d_pkg::DENOM)) &&
		           (rem_c[2] < 25'(2 * lut3d_pkg::DENOM)))
		else $error("quotient estimate off");

	// a stall freezes the pipeline valids
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(pv_s12) && $stable(pv_s6) && pv_s13)
		else $error("pipeline moved during stall");
`endif

endmodule

FILE: tb/lut3d_trilinear_color_map_tb.sv
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_map_tb
// Self-checking bench: loads table corners, streams pixels under random
// back-pressure and configuration changes, checks every mapped pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lut3d_trilinear_color_map_tb;

	localparam int DEPTH = 33 * 33 * 33;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 700;

	typedef struct {
		logic        cmd;
		logic [15:0] addr;
		logic [15:0] er, eg, eb;
		logic [7:0]  pr, pg, pb;
	} in_word_t;

	typedef struct {
		logic [7:0] r, g, b;
	} color_t;

	class color_scoreboard;
		logic [15:0] tab_r[DEPTH];
		logic [15:0] tab_g[DEPTH];
		logic [15:0] tab_b[DEPTH];
		bit          written[DEPTH];
		logic [5:0]  lut_size;
		logic [8:0]  opacity;
		color_t      expected_q[$];
		int          mismatches;

		function new();
			lut_size   = 6'd33;
			opacity    = 9'd256;
			mismatches = 0;
		endfunction

		function int lattice_n();
			if (lut_size < 2) return 2;
			if (lut_size > 33) return 33;
			return lut_size;
		endfunction

		function color_t map_pixel(logic [7:0] pr, logic [7:0] pg, logic [7:0] pb);
			int unsigned n, op, t, ch, gi, bi, gx, bx;
			int unsigned pix[3], lo[3], hi[3], fr[3];
			longint unsigned c[2][2], s, d, m, e0, e1, blended[3];
			color_t res;
			n  = lattice_n();
			op = (opacity > 256) ? 256 : opacity;
			pix[0] = pr; pix[1] = pg; pix[2] = pb;
			for (int k = 0; k < 3; k++) begin
				t     = pix[k] * (n - 1);
				lo[k] = t / 255;
				fr[k] = t % 255;
				hi[k] = lo[k] + ((fr[k] != 0) ? 1 : 0);
			end
			d = longint'(65025) << 16;
			for (ch = 0; ch < 3; ch++) begin
				for (gi = 0; gi < 2; gi++) begin
					for (bi = 0; bi < 2; bi++) begin
						gx = gi ? hi[1] : lo[1];
						bx = bi ? hi[2] : lo[2];
						e0 = entry(ch, (lo[0] * n + gx) * n + bx);
						e1 = entry(ch, (hi[0] * n + gx) * n + bx);
						c[gi][bi] = e0 * (255 - fr[0]) + e1 * fr[0];
					end
				end
				c[0][0] = c[0][0] * (255 - fr[1]) + c[1][0] * fr[1];
				c[0][1] = c[0][1] * (255 - fr[1]) + c[1][1] * fr[1];
				s = c[0][0] * (255 - fr[2]) + c[0][1] * fr[2];
				m = (s + d / 2) / d;
				if (m > 255) m = 255;
				blended[ch] = (pix[ch] * (256 - op) + m * op) >> 8;
			end
			res.r = blended[0][7:0];
			res.g = blended[1][7:0];
			res.b = blended[2][7:0];
			return res;
		endfunction

		function longint unsigned entry(int unsigned ch, int unsigned a);
			if (ch == 0) return tab_r[a];
			if (ch == 1) return tab_g[a];
			return tab_b[a];
		endfunction

		function void note_word(in_word_t w);
			if (w.cmd == lut3d_pkg::CMD_LOAD) begin
				if (w.addr < DEPTH) begin
					tab_r[w.addr]   = w.er;
					tab_g[w.addr]   = w.eg;
					tab_b[w.addr]   = w.eb;
					written[w.addr] = 1'b1;
				end
			end else begin
				expected_q.push_back(map_pixel(w.pr, w.pg, w.pb));
			end
		endfunction

		function void check_pixel(color_t got);
			color_t exp_c;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected pixel %0d %0d %0d", got.r, got.g, got.b);
				return;
			end
			exp_c = expected_q.pop_front();
			if (got.r !== exp_c.r || got.g !== exp_c.g || got.b !== exp_c.b) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: pixel exp %0d %0d %0d got %0d %0d %0d",
						exp_c.r, exp_c.g, exp_c.b, got.r, got.g, got.b);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = lut3d_pkg::CMD_LOAD;
	logic [15:0] entry_address = '0;
	logic [15:0] entry_red = '0, entry_green = '0, entry_blue = '0;
	logic [7:0]  pixel_red = '0, pixel_green = '0, pixel_blue = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_red, out_green, out_blue;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = lut3d_pkg::CFG_LUT_SIZE;
	logic [8:0]  cfg_data = '0;

	color_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int stall_req = 0;
	int stall_left = 0;
	int items_sent = 0;
	int cycles = 0;

	always #2 clk = ~clk;

	lut3d_trilinear_color_map i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.entry_address(entry_address), .entry_red(entry_red),
		.entry_green(entry_green), .entry_blue(entry_blue),
		.pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// receiver side, with an optional long hold-off
	always @(posedge clk) begin
		if (stall_req > 0) begin
			stall_left = stall_req;
			stall_req  = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitors
	always @(posedge clk) begin
		in_word_t w;
		color_t   c;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				w = '{cmd, entry_address, entry_red, entry_green, entry_blue,
					pixel_red, pixel_green, pixel_blue};
				sb.note_word(w);
			end
			if (out_valid && out_ready) begin
				c = '{out_red, out_green, out_blue};
				sb.check_pixel(c);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lut3d_pkg::CFG_LUT_SIZE) sb.lut_size = cfg_data[5:0];
				else sb.opacity = cfg_data;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// called at a rising edge, returns at the edge that accepts the word
	task automatic send_word(logic c, logic [15:0] a, logic [15:0] r, logic [15:0] g,
		logic [15:0] b, logic [7:0] pr, logic [7:0] pg, logic [7:0] pb);
		logic rdy;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		entry_address <= a;
		entry_red     <= r;
		entry_green   <= g;
		entry_blue    <= b;
		pixel_red     <= pr;
		pixel_green   <= pg;
		pixel_blue    <= pb;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		items_sent++;
	endtask

	function automatic logic [15:0] pick_entry(int mode);
		if (mode == 0) return 16'h0000;
		if (mode == 1) return 16'hFFFF;
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_chan();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int lower_index(logic [7:0] p, int n);
		return (p * (n - 1)) / 255;
	endfunction

	// load the eight lattice corners as needed, then send the pixel
	task automatic map_with_corners(logic [7:0] pr, logic [7:0] pg, logic [7:0] pb,
		int mode, int reload_pct);
		int n, a;
		int lo[3], hi[3];
		logic [7:0] p[3];
		n = sb.lattice_n();
		p[0] = pr; p[1] = pg; p[2] = pb;
		for (int k = 0; k < 3; k++) begin
			lo[k] = lower_index(p[k], n);
			hi[k] = ((p[k] * (n - 1)) % 255 != 0) ? lo[k] + 1 : lo[k];
		end
		for (int i = 0; i < 8; i++) begin
			a = ((i[2] ? hi[0] : lo[0]) * n + (i[1] ? hi[1] : lo[1])) * n
				+ (i[0] ? hi[2] : lo[2]);
			if (!sb.written[a] || $urandom_range(99) < reload_pct)
				send_word(lut3d_pkg::CMD_LOAD, 16'(a), pick_entry(mode), pick_entry(mode),
					pick_entry(mode), 8'($urandom), 8'($urandom), 8'($urandom));
		end
		send_word(lut3d_pkg::CMD_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), pr, pg, pb);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [8:0] val);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	int seg_sizes[8]   = '{2, 33, 0, 63, 5, 17, 1, 3};
	int seg_opacity[8] = '{256, 0, 128, 511, 257, 200, 255, 64};

	initial begin
		int goal;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, corner values at extremes, ignored loads
		map_with_corners(8'd0, 8'd0, 8'd0, 1, 100);
		map_with_corners(8'd255, 8'd255, 8'd255, 0, 100);
		send_word(lut3d_pkg::CMD_LOAD, 16'd35937, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			8'd0, 8'd0, 8'd0);
		send_word(lut3d_pkg::CMD_LOAD, 16'hFFFF, 16'h0, 16'h0, 16'h0,
			8'hFF, 8'hFF, 8'hFF);
		map_with_corners(8'd255, 8'd255, 8'd255, 2, 0);
		map_with_corners(8'd255, 8'd0, 8'd128, 2, 100);
		map_with_corners(8'd1, 8'd254, 8'd127, 2, 100);

		for (int seg = 0; seg < 8; seg++) begin
			drain();
			write_reg(lut3d_pkg::CFG_LUT_SIZE, 9'(seg_sizes[seg]));
			write_reg(lut3d_pkg::CFG_OPACITY, 9'(seg_opacity[seg]));
			if (seg < 3) begin
				send_idle = 35; recv_idle = 68;
			end else if (seg < 6) begin
				send_idle = 68; recv_idle = 35;
			end else begin
				send_idle = 0; recv_idle = 0;
			end
			if (seg == 7) stall_req = 300;
			goal = items_sent + ITEM_TARGET / 8;
			while (items_sent < goal) begin
				case ($urandom_range(9))
					0: send_word(lut3d_pkg::CMD_LOAD, 16'($urandom_range(DEPTH, 65535)),
						pick_entry(2), pick_entry(2), pick_entry(2),
						8'($urandom), 8'($urandom), 8'($urandom));
					1: send_word(lut3d_pkg::CMD_LOAD, 16'($urandom_range(DEPTH - 1)),
						pick_entry(2), pick_entry(2), pick_entry(2),
						8'($urandom), 8'($urandom), 8'($urandom));
					default: map_with_corners(pick_chan(), pick_chan(), pick_chan(), 2, 20);
				endcase
			end
		end

		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
